[hw/rtl/scsf_pkg.sv]
// scsf_pkg: shared widths, codes and stage structs for the column singleton finder
// used by scsf_detect, scsf_count and sparse_column_singleton_finder
package scsf_pkg;

  localparam int ROW_W    = 10;
  localparam int MAG_W    = 32;
  localparam int CNT_W    = 11;
  localparam int PTR_W    = 21;
  localparam int FC_CMP_W = CNT_W + 1;
  localparam int ENT_W    = ROW_W + 1;   // row entry: {taken, position}
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [CNT_W-1:0]    CNT_SAT    = '1;
  localparam logic [PTR_W-1:0]    PTR_SAT    = '1;
  localparam logic [FC_CMP_W-1:0] FC_CMP_SAT = FC_CMP_W'(1 << CNT_W);

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_TOLERANCE = 1'b0;

  typedef enum logic [1:0] {
    FUNC_DETECT  = 2'd0,
    FUNC_PERMUTE = 2'd1,
    FUNC_COUNT   = 2'd2,
    FUNC_READ    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    COL_NONE = 2'd0,
    COL_DEAD = 2'd1,
    COL_LIVE = 2'd2,
    COL_STOP = 2'd3
  } col_status_t;

  // word handed from the detect stage to the count stage
  typedef struct packed {
    func_t                func;
    logic                 present;
    logic                 last;
    logic                 in_range;
    logic                 taken;
    logic                 cnt_ok;
    col_status_t          status;
    logic [ROW_W-1:0]     srow;
    logic [ROW_W-1:0]     perm;
    logic [CNT_W-1:0]     fc_out;
    logic [FC_CMP_W-1:0]  fc_cmp;
    logic [CNT_W-1:0]     fr;
  } b2c_t;

  // finished result word
  typedef struct packed {
    col_status_t       status;
    logic [ROW_W-1:0]  srow;
    logic [CNT_W-1:0]  fc;
    logic [CNT_W-1:0]  fr;
    logic [ROW_W-1:0]  perm;
    logic [PTR_W-1:0]  col_ptr;
    logic [CNT_W-1:0]  row_cnt;
  } result_t;

endpackage

[hw/rtl/sparse_column_singleton_finder.sv]
// sparse_column_singleton_finder: top level, pipeline control, row memories,
// clearing pass, tolerance register; uses scsf_pkg, scsf_ram, scsf_detect, scsf_count
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+---------------------------------------
//   in_      | input     | in_valid / in_stall   | func, row_index, magnitude, flags
//   out_     | output    | out_valid / out_stall | status, rows, counts, pointer
//   apb      | input     | psel/penable/pready   | tolerance at byte address 0
//
// one word per cycle sustained while out_stall is low; after acceptance a word passes the
// row entry memory read, then the count memory read, each a registered read with forwarding.
// after reset the row and count memories are cleared, one entry a cycle, over all
// min(ROWS_MAX, 1024) entries with in_stall high; apb writes are taken throughout.
// out_stall backs up through the stages; in_stall rises only during clearing or when all stages are full.
module sparse_column_singleton_finder
  import scsf_pkg::*;
#(
  parameter int ROWS_MAX = 1024,
  parameter int COLS_MAX = 1024
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_func,
  input  logic [ROW_W-1:0]    in_row_index,
  input  logic [MAG_W-1:0]    in_magnitude,
  input  logic                in_entry_present,
  input  logic                in_last_in_column,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_column_status,
  output logic [ROW_W-1:0]    out_singleton_row,
  output logic [CNT_W-1:0]    out_singleton_columns,
  output logic [CNT_W-1:0]    out_singleton_rows,
  output logic [ROW_W-1:0]    out_permuted_row,
  output logic [PTR_W-1:0]    out_column_pointer,
  output logic [CNT_W-1:0]    out_row_count,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int MEM_DEPTH = (ROWS_MAX < (1 << ROW_W)) ? ROWS_MAX : (1 << ROW_W);
  localparam int AW        = $clog2(MEM_DEPTH);

  // configuration
  logic [MAG_W-1:0] tol_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOLERANCE) ? tol_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_TOLERANCE) begin
      tol_r <= pwdata;
    end
  end

  // clearing pass
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == AW'(MEM_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  // stage flow
  logic b_vld_r, c_vld_r, out_vld_r;
  logic mo, adv_c, ld_c, adv_b, ld_b, in_acc;

  assign mo       = !out_vld_r || !out_stall;
  assign adv_c    = c_vld_r && mo;
  assign ld_c     = !c_vld_r || adv_c;
  assign adv_b    = b_vld_r && ld_c;
  assign ld_b     = !b_vld_r || adv_b;
  assign in_stall = clr_busy_r || !ld_b;
  assign in_acc   = in_valid && !in_stall;

  // detect stage input register
  func_t             b_func_r;
  logic [ROW_W-1:0]  b_row_r;
  logic [MAG_W-1:0]  b_mag_r;
  logic              b_present_r;
  logic              b_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (ld_b) begin
      b_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_func_r    <= func_t'(in_func);
      b_row_r     <= in_row_index;
      b_mag_r     <= in_magnitude;
      b_present_r <= in_entry_present;
      b_last_r    <= in_last_in_column;
    end
  end

  // row entry memory {taken, position}
  logic              wr1_en;
  logic [AW-1:0]     wr1_addr;
  logic [ENT_W-1:0]  wr1_data;
  logic [AW-1:0]     rd1_addr;
  logic [ENT_W-1:0]  rd1_q;
  logic [ENT_W-1:0]  ent;
  logic [AW-1:0]     b_addr;
  logic              fwd1_en_r;
  logic [AW-1:0]     fwd1_addr_r;
  logic [ENT_W-1:0]  fwd1_data_r;

  assign b_addr   = AW'(b_row_r);
  // a held word re-reads its own row so the data tracks later writes
  assign rd1_addr = ld_b ? AW'(in_row_index) : b_addr;

  scsf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MEM_DEPTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (clr_busy_r || wr1_en),
    .waddr (clr_busy_r ? clr_addr_r : wr1_addr),
    .wdata (clr_busy_r ? '0 : wr1_data),
    .raddr (rd1_addr),
    .rdata (rd1_q)
  );

  // write landing on the same edge as the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd1_en_r <= 1'b0;
    end else begin
      fwd1_en_r <= wr1_en;
    end
  end

  always_ff @(posedge clk) begin
    fwd1_addr_r <= wr1_addr;
    fwd1_data_r <= wr1_data;
  end

  assign ent = (fwd1_en_r && fwd1_addr_r == b_addr) ? fwd1_data_r : rd1_q;

  logic [AW-1:0] cnt_addr;
  b2c_t          b_info;

  scsf_detect #(
    .ROWS_MAX (ROWS_MAX),
    .COLS_MAX (COLS_MAX),
    .AW       (AW)
  ) u_detect (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (adv_b),
    .func      (b_func_r),
    .row       (b_row_r),
    .mag       (b_mag_r),
    .present   (b_present_r),
    .last      (b_last_r),
    .tolerance (tol_r),
    .ent       (ent),
    .wr_en     (wr1_en),
    .wr_addr   (wr1_addr),
    .wr_data   (wr1_data),
    .cnt_addr  (cnt_addr),
    .info      (b_info)
  );

  // count stage register
  b2c_t          c_info_r;
  logic [AW-1:0] c_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (ld_c) begin
      c_vld_r <= adv_b;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      c_info_r <= b_info;
      c_addr_r <= cnt_addr;
    end
  end

  // singleton row count memory
  logic              wr2_en;
  logic [CNT_W-1:0]  wr2_data;
  logic [CNT_W-1:0]  rd2_q;
  logic [CNT_W-1:0]  cnt;
  logic              fwd2_en_r;
  logic [AW-1:0]     fwd2_addr_r;
  logic [CNT_W-1:0]  fwd2_data_r;

  scsf_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MEM_DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (clr_busy_r || wr2_en),
    .waddr (clr_busy_r ? clr_addr_r : c_addr_r),
    .wdata (clr_busy_r ? '0 : wr2_data),
    .raddr (adv_b ? cnt_addr : c_addr_r),
    .rdata (rd2_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd2_en_r <= 1'b0;
    end else begin
      fwd2_en_r <= wr2_en;
    end
  end

  always_ff @(posedge clk) begin
    fwd2_addr_r <= c_addr_r;
    fwd2_data_r <= wr2_data;
  end

  assign cnt = (fwd2_en_r && fwd2_addr_r == c_addr_r) ? fwd2_data_r : rd2_q;

  result_t c_res;

  scsf_count u_count (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (adv_c),
    .info    (c_info_r),
    .cnt     (cnt),
    .wr_en   (wr2_en),
    .wr_data (wr2_data),
    .res     (c_res)
  );

  // output register
  result_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (mo) begin
      out_vld_r <= adv_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      out_r <= c_res;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_column_status     = out_r.status;
  assign out_singleton_row     = out_r.srow;
  assign out_singleton_columns = out_r.fc;
  assign out_singleton_rows    = out_r.fr;
  assign out_permuted_row      = out_r.perm;
  assign out_column_pointer    = out_r.col_ptr;
  assign out_row_count         = out_r.row_cnt;

`ifndef SYNTH
  a_clear_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!b_vld_r && !c_vld_r && !out_vld_r))
    else $error("word in flight during memory clear");

  a_clear_no_pipe_write: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!wr1_en && !wr2_en))
    else $error("stage write collides with memory clear");

  a_count_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv_c |=> out_vld_r)
    else $error("count stage word lost on its way to the output");
`endif

endmodule

[hw/rtl/scsf_ram.sv]
// scsf_ram: generic single-write, single-read memory with registered read data
// no dependencies
module scsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/scsf_detect.sv]
// scsf_detect: singleton search and row permutation stage, owns the column scan state
// depends on scsf_pkg; reads and writes the row entry memory through the top level
module scsf_detect
  import scsf_pkg::*;
#(
  parameter int ROWS_MAX = 1024,
  parameter int COLS_MAX = 1024,
  parameter int AW       = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  func_t             func,
  input  logic [ROW_W-1:0]  row,
  input  logic [MAG_W-1:0]  mag,
  input  logic              present,
  input  logic              last,
  input  logic [MAG_W-1:0]  tolerance,
  input  logic [ENT_W-1:0]  ent,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [ENT_W-1:0]  wr_data,
  output logic [AW-1:0]     cnt_addr,
  output b2c_t              info
);

  localparam int FC_W = $clog2(COLS_MAX + 1);

  logic [1:0]        free_r, free_nxt, free_cur;
  logic [ROW_W-1:0]  cand_row_r, cand_row_nxt, cand_row_cur;
  logic [MAG_W-1:0]  cand_mag_r, cand_mag_nxt, cand_mag_cur;
  logic [FC_W-1:0]   fc_r, fc_nxt;
  logic [CNT_W-1:0]  fr_r, fr_nxt;
  logic              stop_r, stop_nxt;
  logic [CNT_W-1:0]  rank_r, rank_nxt;

  logic              row_ok;
  logic              taken;
  logic [ROW_W-1:0]  pos;
  logic              take;
  logic              wr_req;
  logic [ROW_W-1:0]  new_pos;

  assign row_ok  = 32'(row) < 32'(ROWS_MAX);
  assign taken   = ent[ROW_W];
  assign pos     = ent[ROW_W-1:0];
  assign new_pos = fr_r[ROW_W-1:0] + rank_r[ROW_W-1:0];

  // a repeated row counts again, only the first free row becomes the candidate
  assign take         = present && row_ok && !taken && (free_r < 2'd2);
  assign free_cur     = take ? free_r + 2'd1 : free_r;
  assign cand_row_cur = (take && free_r == 2'd0) ? row : cand_row_r;
  assign cand_mag_cur = (take && free_r == 2'd0) ? mag : cand_mag_r;

  always_comb begin
    free_nxt     = free_r;
    cand_row_nxt = cand_row_r;
    cand_mag_nxt = cand_mag_r;
    fc_nxt       = fc_r;
    fr_nxt       = fr_r;
    stop_nxt     = stop_r;
    rank_nxt     = rank_r;
    wr_req       = 1'b0;
    wr_addr      = AW'(row);
    wr_data      = '0;
    cnt_addr     = AW'(row);
    info         = '0;
    info.func     = func;
    info.present  = present;
    info.last     = last;
    info.in_range = row_ok;
    info.taken    = taken;
    info.status   = COL_NONE;

    unique case (func)
      FUNC_DETECT: begin
        if (!stop_r) begin
          free_nxt     = free_cur;
          cand_row_nxt = cand_row_cur;
          cand_mag_nxt = cand_mag_cur;
          if (last) begin
            free_nxt = '0;
            if (fc_r >= FC_W'(COLS_MAX)) begin
              stop_nxt    = 1'b1;
              info.status = COL_STOP;
            end else if (free_cur == 2'd0) begin
              fc_nxt      = fc_r + FC_W'(1);
              info.status = COL_DEAD;
            end else if (free_cur == 2'd1 && cand_mag_cur > tolerance) begin
              wr_req      = 1'b1;
              wr_addr     = AW'(cand_row_cur);
              wr_data     = {1'b1, fr_r[ROW_W-1:0]};
              fr_nxt      = fr_r + CNT_W'(1);
              fc_nxt      = fc_r + FC_W'(1);
              info.status = COL_LIVE;
              info.srow   = cand_row_cur;
            end else begin
              stop_nxt    = 1'b1;
              info.status = COL_STOP;
            end
          end
        end
      end
      FUNC_PERMUTE: begin
        if (row_ok) begin
          if (taken) begin
            info.perm = pos;
          end else begin
            wr_req    = 1'b1;
            wr_data   = {1'b0, new_pos};
            info.perm = new_pos;
            if (rank_r != CNT_SAT) begin
              rank_nxt = rank_r + CNT_W'(1);
            end
          end
        end
      end
      FUNC_COUNT: begin
        cnt_addr    = AW'(pos);
        info.cnt_ok = 32'(pos) < 32'(ROWS_MAX);
      end
      FUNC_READ: begin
        cnt_addr    = AW'(row);
        info.cnt_ok = row_ok;
      end
      default: begin
        info.status = COL_NONE;
      end
    endcase

    info.fc_out = CNT_W'(fc_nxt);
    info.fc_cmp = (32'(fc_nxt) >= 32'(FC_CMP_SAT)) ? FC_CMP_SAT : FC_CMP_W'(fc_nxt);
    info.fr     = fr_nxt;
  end

  assign wr_en = advance && wr_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r     <= '0;
      cand_row_r <= '0;
      cand_mag_r <= '0;
      fc_r       <= '0;
      fr_r       <= '0;
      stop_r     <= 1'b0;
      rank_r     <= '0;
    end else if (advance) begin
      free_r     <= free_nxt;
      cand_row_r <= cand_row_nxt;
      cand_mag_r <= cand_mag_nxt;
      fc_r       <= fc_nxt;
      fr_r       <= fr_nxt;
      stop_r     <= stop_nxt;
      rank_r     <= rank_nxt;
    end
  end

endmodule

[hw/rtl/scsf_count.sv]
// scsf_count: entry count stage, singleton row counts and remaining column pointers
// depends on scsf_pkg; reads and writes the count memory through the top level
module scsf_count
  import scsf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  b2c_t              info,
  input  logic [CNT_W-1:0]  cnt,
  output logic              wr_en,
  output logic [CNT_W-1:0]  wr_data,
  output result_t           res
);

  logic [CNT_W-1:0]  cpc_r, cpc_nxt;
  logic [PTR_W-1:0]  rem_r, rem_nxt;

  logic is_count;
  logic is_read;
  logic hit_taken;
  logic free_ent;

  assign is_count  = info.func == FUNC_COUNT;
  assign is_read   = info.func == FUNC_READ;
  assign hit_taken = info.present && info.in_range && info.taken;
  // only columns past the singleton block feed the remaining part
  assign free_ent  = info.present && info.in_range && !info.taken &&
                     ({1'b0, cpc_r} >= info.fc_cmp);

  assign rem_nxt = (is_count && free_ent && rem_r != PTR_SAT) ? rem_r + PTR_W'(1) : rem_r;
  assign cpc_nxt = (is_count && info.last && cpc_r != CNT_SAT) ? cpc_r + CNT_W'(1) : cpc_r;

  assign wr_en   = advance && is_count && hit_taken && info.cnt_ok && cnt != CNT_SAT;
  assign wr_data = cnt + CNT_W'(1);

  always_comb begin
    res         = '0;
    res.status  = info.status;
    res.srow    = info.srow;
    res.fc      = info.fc_out;
    res.fr      = info.fr;
    res.perm    = info.perm;
    res.col_ptr = (is_count && info.last) ? rem_nxt : '0;
    res.row_cnt = (is_read && info.cnt_ok) ? cnt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpc_r <= '0;
      rem_r <= '0;
    end else if (advance) begin
      cpc_r <= cpc_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule
